FILE: rtl/rgch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgch_pkg: shared types and constants of the chromaticity histogram
// Bin and counter sizing, request codes, queue entry layout and FSM states.
// ----------------------------------------------------------------------------
package rgch_pkg;

	localparam int BIN_BITS    = 8;
	localparam int COUNT_BITS  = 20;
	localparam int PIX_W       = 8;
	localparam int IDX_W       = 8;
	localparam int OP_W        = 2;
	localparam int LUM_W       = PIX_W + 2;
	localparam int NUM_W       = PIX_W + BIN_BITS;
	localparam int TRIAL_W     = LUM_W + BIN_BITS;
	localparam int STEP_W      = $clog2(BIN_BITS);
	localparam int ADDR_W      = 2 * BIN_BITS;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_ADD      = 2'd0,
		OP_READ     = 2'd1,
		OP_READ_CLR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_READ,
		CMD_READ_CLR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [ADDR_W-1:0] addr;
	} rgch_cmd_t;

	typedef struct packed {
		logic      valid;
		rgch_cmd_t cmd;
	} rgch_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rgch_qstat_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_ISSUE,
		B_EXEC
	} back_state_t;

endpackage
`default_nettype wire

FILE: rtl/rgch_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgch_front: request intake and bin computation
// Takes requests, skips black pixels, divides to find the bins and queues work.
// ----------------------------------------------------------------------------
module rgch_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [rgch_pkg::OP_W-1:0]   operation,
	input  wire logic [rgch_pkg::PIX_W-1:0]  red,
	input  wire logic [rgch_pkg::PIX_W-1:0]  green,
	input  wire logic [rgch_pkg::PIX_W-1:0]  blue,
	input  wire logic [rgch_pkg::IDX_W-1:0]  bin_red,
	input  wire logic [rgch_pkg::IDX_W-1:0]  bin_green,
	input  wire logic                        clearing,
	input  wire rgch_pkg::rgch_qstat_t       qstat,
	output rgch_pkg::rgch_push_t             push
);
	import rgch_pkg::*;

	front_state_t        state_q, state_d;
	logic                load;
	logic [LUM_W-1:0]    lum;
	logic [NUM_W-1:0]    num_r, num_g;
	logic [NUM_W-1:0]    rem_r_q, rem_g_q;
	logic [LUM_W-1:0]    lum_q;
	logic [BIN_BITS-1:0] qr_q, qg_q;
	logic [STEP_W-1:0]   step_q;
	logic [TRIAL_W-1:0]  trial;
	logic                ge_r, ge_g;

	assign lum   = {2'b00, red} + {2'b00, green} + {2'b00, blue};
	// scale by 2^BIN_BITS - 1 as shift and subtract
	assign num_r = {red, {BIN_BITS{1'b0}}} - {{BIN_BITS{1'b0}}, red};
	assign num_g = {green, {BIN_BITS{1'b0}}} - {{BIN_BITS{1'b0}}, green};

	assign trial = {{BIN_BITS{1'b0}}, lum_q} << step_q;
	assign ge_r  = {{(TRIAL_W-NUM_W){1'b0}}, rem_r_q} >= trial;
	assign ge_g  = {{(TRIAL_W-NUM_W){1'b0}}, rem_g_q} >= trial;

	always_comb begin
		state_d        = state_q;
		in_stall       = 1'b1;
		load           = 1'b0;
		push.valid     = 1'b0;
		push.cmd.kind  = CMD_READ;
		push.cmd.addr  = {bin_red[BIN_BITS-1:0], bin_green[BIN_BITS-1:0]};
		case (state_q)
			F_IDLE: begin
				in_stall = clearing || qstat.full;
				if (in_valid && !in_stall) begin
					case (operation)
						OP_ADD: begin
							if (lum != '0) begin
								load    = 1'b1;
								state_d = F_DIV;
							end
						end
						OP_READ: begin
							push.valid    = 1'b1;
							push.cmd.kind = CMD_READ;
						end
						OP_READ_CLR: begin
							push.valid    = 1'b1;
							push.cmd.kind = CMD_READ_CLR;
						end
						default: ;
					endcase
				end
			end
			F_DIV: begin
				if (step_q == '0) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				push.cmd.kind = CMD_ADD;
				push.cmd.addr = {qr_q, qg_q};
				if (!qstat.full) begin
					push.valid = 1'b1;
					state_d    = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// restoring division, one quotient bit of each ratio per cycle
	always_ff @(posedge clk) begin
		if (load) begin
			rem_r_q <= num_r;
			rem_g_q <= num_g;
			lum_q   <= lum;
			qr_q    <= '0;
			qg_q    <= '0;
			step_q  <= STEP_W'(BIN_BITS - 1);
		end else if (state_q == F_DIV) begin
			if (ge_r) begin
				rem_r_q <= rem_r_q - trial[NUM_W-1:0];
			end
			if (ge_g) begin
				rem_g_q <= rem_g_q - trial[NUM_W-1:0];
			end
			qr_q   <= {qr_q[BIN_BITS-2:0], ge_r};
			qg_q   <= {qg_q[BIN_BITS-2:0], ge_g};
			step_q <= step_q - STEP_W'(1);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/rgch_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgch_queue: request queue between intake and store
// Small FIFO of decoded requests with a fill count.
// ----------------------------------------------------------------------------
module rgch_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rgch_pkg::rgch_push_t  push,
	input  wire logic                  pop,
	output rgch_pkg::rgch_cmd_t        head,
	output rgch_pkg::rgch_qstat_t      qstat
);
	import rgch_pkg::*;

	rgch_cmd_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign head        = entry_q[rd_ptr_q];
	assign qstat.full  = fill_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign qstat.empty = fill_q == '0;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push.valid, pop})
				2'b10:   fill_q <= fill_q + (QPTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (QPTR_W+1)'(1);
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && qstat.full && !pop))
		else $error("request pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("request popped from an empty queue");

endmodule
`default_nettype wire

FILE: rtl/rgch_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgch_back: bin store and request execution
// Clears the store after reset, then reads, updates and reports bin counts.
// ----------------------------------------------------------------------------
module rgch_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire rgch_pkg::rgch_cmd_t             head,
	input  wire rgch_pkg::rgch_qstat_t           qstat,
	output logic                                 pop,
	output logic                                 clearing,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [rgch_pkg::COUNT_BITS-1:0]      bin_count
);
	import rgch_pkg::*;

	back_state_t           state_q, state_d;
	logic [COUNT_BITS-1:0] store_q [STORE_DEPTH];
	logic [COUNT_BITS-1:0] rdata_q;
	logic [COUNT_BITS-1:0] out_data_q;
	logic                  out_valid_q;
	logic [ADDR_W-1:0]     clr_addr_q;
	rgch_cmd_t             cmd_q;
	logic                  rd_en, we, load_out, out_free;
	logic [ADDR_W-1:0]     waddr;
	logic [COUNT_BITS-1:0] wdata;

	assign out_free  = !out_valid_q || !out_stall;
	assign clearing  = state_q == B_CLEAR;
	assign out_valid = out_valid_q;
	assign bin_count = out_data_q;

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		rd_en    = 1'b0;
		we       = 1'b0;
		load_out = 1'b0;
		waddr    = cmd_q.addr;
		wdata    = '0;
		case (state_q)
			B_CLEAR: begin
				we    = 1'b1;
				waddr = clr_addr_q;
				if (clr_addr_q == '1) begin
					state_d = B_ISSUE;
				end
			end
			B_ISSUE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					rd_en   = 1'b1;
					state_d = B_EXEC;
				end
			end
			B_EXEC: begin
				case (cmd_q.kind)
					CMD_ADD: begin
						we      = rdata_q != COUNT_MAX;
						wdata   = rdata_q + COUNT_BITS'(1);
						state_d = B_ISSUE;
					end
					CMD_READ: begin
						if (out_free) begin
							load_out = 1'b1;
							state_d  = B_ISSUE;
						end
					end
					CMD_READ_CLR: begin
						if (out_free) begin
							load_out = 1'b1;
							we       = 1'b1;
							state_d  = B_ISSUE;
						end
					end
					default: state_d = B_ISSUE;
				endcase
			end
			default: state_d = B_ISSUE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (load_out) begin
			out_data_q <= rdata_q;
		end
	end

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= store_q[head.addr];
		end
	end

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && we))
		else $error("store read issued while a write is pending");

	a_issue_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> state_q == B_EXEC)
		else $error("store read not followed by execution");

	a_read_reports: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q && out_data_q == $past(rdata_q))
		else $error("read request did not reach the output register");

endmodule
`default_nettype wire

FILE: rtl/rg_chromaticity_histogram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rg_chromaticity_histogram: two-dimensional rg chromaticity histogram
// Counts pixels per (red, green) chromaticity bin and serves bin reads.
// ----------------------------------------------------------------------------
// A pixel request bins R and G by floor(255*R/(R+G+B)) and floor(255*G/(R+G+B))
// and increments that saturating 20-bit counter; black pixels and operation
// code 3 are accepted and dropped with no result. A read request returns one
// bin's count, and the read-and-clear request zeroes the bin after reading it.
// After reset the block sweeps the 65536-entry store to zero, one entry per
// cycle, and holds in_stall high while it does so. Afterwards a read request
// is pushed to the queue as it is taken; a pixel request holds the intake
// while the shared restoring divider produces one quotient bit of both ratios
// per cycle, and until its bins fit in the queue. Each request then passes
// the store in B_ISSUE (registered read) and B_EXEC (write-back or output,
// which waits on out_stall); requests are executed and answered in arrival order.
// ----------------------------------------------------------------------------
module rg_chromaticity_histogram (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [rgch_pkg::OP_W-1:0]       operation,
	input  wire logic [rgch_pkg::PIX_W-1:0]      red,
	input  wire logic [rgch_pkg::PIX_W-1:0]      green,
	input  wire logic [rgch_pkg::PIX_W-1:0]      blue,
	input  wire logic [rgch_pkg::IDX_W-1:0]      bin_red,
	input  wire logic [rgch_pkg::IDX_W-1:0]      bin_green,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [rgch_pkg::COUNT_BITS-1:0]      bin_count
);
	import rgch_pkg::*;

	rgch_push_t  push;
	rgch_qstat_t qstat;
	rgch_cmd_t   head;
	logic        pop;
	logic        clearing;

	// intake: decode each request, divide pixels into bins, drop no-ops
	rgch_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.bin_red   (bin_red),
		.bin_green (bin_green),
		.clearing  (clearing),
		.qstat     (qstat),
		.push      (push)
	);

	// hold decoded requests so intake and store stall independently
	rgch_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// store: clear after reset, then execute queued requests one at a time
	rgch_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bin_count (bin_count)
	);

endmodule
`default_nettype wire
